// ===== sv/pds_pkg.sv =====
// shared types, constants and helpers for the pll divider search
package pds_pkg;

   // divider search limits
   localparam logic [9:0]  REF_DIV_FLOOR  = 10'd2;
   localparam logic [9:0]  REF_DIV_CEIL   = 10'd1023;
   localparam logic [11:0] MIN_FB_DIV     = 12'd4;
   localparam logic [11:0] FB_DIV_LIMIT   = 12'd2048;
   localparam logic [7:0]  POST_DIV_FIRST = 8'd1;

   // arithmetic constants
   localparam logic [13:0] FREQ_SCALE   = 14'd10000;
   localparam logic [9:0]  KHZ_SCALE    = 10'd1000;
   localparam logic [31:0] ERR_WINDOW   = 32'd100;
   localparam logic [31:0] NO_FREQ      = 32'hffffffff;
   // ceil(2^45 / 10000), exact quotient by 10000 for any 32-bit value
   localparam logic [31:0] DOT_RECIP    = 32'hd1b71759;

   // divider operand widths
   localparam int NUM_W = 41;
   localparam int DEN_W = 17;
   localparam int IDX_W = 6;

   // top bit index of each division
   localparam logic [IDX_W-1:0] TOP_PIN = 6'd15;
   localparam logic [IDX_W-1:0] TOP_VCO = 6'd27;
   localparam logic [IDX_W-1:0] TOP_CUR = 6'd40;

   // configuration register indexes
   localparam logic [2:0] CSR_REF_CLOCK   = 3'd0;
   localparam logic [2:0] CSR_FIXED_REF   = 3'd1;
   localparam logic [2:0] CSR_PIN_MIN     = 3'd2;
   localparam logic [2:0] CSR_PIN_MAX     = 3'd3;
   localparam logic [2:0] CSR_VCO_MIN     = 3'd4;
   localparam logic [2:0] CSR_VCO_MAX     = 3'd5;
   localparam logic [2:0] CSR_PREF_VCO    = 3'd6;
   localparam logic [2:0] CSR_POST_MAX    = 3'd7;

   // option flag bits
   localparam int FLG_FIXED_REF = 0;
   localparam int FLG_NO_ODD    = 1;
   localparam int FLG_LEGACY    = 2;
   localparam int FLG_LOW_REF   = 3;
   localparam int FLG_HIGH_REF  = 4;
   localparam int FLG_LOW_FB    = 5;
   localparam int FLG_HIGH_FB   = 6;
   localparam int FLG_LOW_POST  = 7;
   localparam int FLG_HIGH_POST = 8;

   // what the shared divider is asked to compute
   typedef enum logic [2:0] {
      DIV_MID = 3'd0,
      DIV_RD  = 3'd1,
      DIV_VCO = 3'd2,
      DIV_CUR = 3'd3
   } div_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        rb_step;
      logic        post_init;
      logic        post_inc;
      logic        rd_init;
      logic        rd_inc;
      logic        fb_init;
      logic        vco_cap;
      logic        vco_step;
      logic        eval;
      logic        rsp_load;
   } pds_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
      logic rb_more;
      logic pin_ok;
      logic post_ok;
      logic post_skip;
      logic rd_ok;
      logic rd_zero;
      logic fb_more;
      logic vco_ok;
      logic rsp_free;
   } pds_stat_type;

   // magnitude of a two's-complement word
   function automatic logic [31:0] mag32(input logic [31:0] x);
      mag32 = x[31] ? (32'd0 - x) : x;
   endfunction

   // post dividers left out of the legacy set
   function automatic logic legacy_skip(input logic [7:0] p);
      legacy_skip = (p == 8'd5) || (p == 8'd7) || (p == 8'd9) || (p == 8'd10) ||
                    (p == 8'd11) || (p == 8'd13) || (p == 8'd14) || (p == 8'd15);
   endfunction

endpackage

// ===== sv/pds_div.sv =====
// restoring divider, one quotient bit per cycle
module pds_div
   import pds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [IDX_W-1:0] top,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;

   // one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[idx_ff]};
      if (start) begin
         busy_in = 1'b1;
         idx_in  = top;
         num_in  = num;
         den_in  = den;
         q_in    = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in        = DEN_W'(trial - {1'b0, den_ff});
            q_in[idx_ff]  = 1'b1;
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_ends : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_rem_small : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && den_ff != '0) |=> rem_ff < den_ff)
      else $error("divider remainder out of range");

endmodule

// ===== sv/pds_dpath.sv =====
// search datapath: config registers, loop counters, best candidate, divider
module pds_dpath
   import pds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pds_cmd_type  cmd,
   output pds_stat_type stat,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wr_data,
   input  logic [31:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata
);

   // configuration registers
   logic [15:0] ref_clock_ff;
   logic [9:0]  fixed_ref_ff;
   logic [15:0] pin_min_ff;
   logic [15:0] pin_max_ff;
   logic [31:0] vco_min_ff;
   logic [31:0] vco_max_ff;
   logic [31:0] pref_vco_ff;
   logic [6:0]  post_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= 16'd2700;
         fixed_ref_ff <= 10'd12;
         pin_min_ff   <= 16'd0;
         pin_max_ff   <= 16'hffff;
         vco_min_ff   <= 32'd0;
         vco_max_ff   <= 32'hffffffff;
         pref_vco_ff  <= 32'd0;
         post_max_ff  <= 7'd127;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_CLOCK: ref_clock_ff <= csr_wr_data[15:0];
            CSR_FIXED_REF: fixed_ref_ff <= csr_wr_data[9:0];
            CSR_PIN_MIN:   pin_min_ff   <= csr_wr_data[15:0];
            CSR_PIN_MAX:   pin_max_ff   <= csr_wr_data[15:0];
            CSR_VCO_MIN:   vco_min_ff   <= csr_wr_data;
            CSR_VCO_MAX:   vco_max_ff   <= csr_wr_data;
            CSR_PREF_VCO:  pref_vco_ff  <= csr_wr_data;
            CSR_POST_MAX:  post_max_ff  <= csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   // request and search registers
   logic [32:0] target_ff;
   logic [8:0]  flags_ff;
   logic [9:0]  rlo_ff, rhi_ff;
   logic [7:0]  post_ff;
   logic [10:0] rd_ff;
   logic [11:0] flo_ff, fhi_ff;
   logic [31:0] vco_ff;
   logic [29:0] rc10k_ff;
   logic [16:0] rp_ff;
   logic        found_ff;
   logic [6:0]  b_post_ff;
   logic [9:0]  b_ref_ff;
   logic [10:0] b_fb_ff;
   logic [31:0] b_freq_ff, b_err_ff, b_vd_ff;
   logic [18:0] dot_ff;
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   // divider hookup
   logic             div_busy, div_done;
   logic [NUM_W-1:0] quot;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [IDX_W-1:0] div_top;

   logic [10:0] mid_sum;
   logic [9:0]  mid;
   logic [12:0] fb_sum;
   logic [10:0] fb;
   logic [15:0] pin;
   logic [31:0] cur, err, vd;
   logic        better, exact, prefer, take;
   logic [31:0] fin_freq;
   logic [63:0] dot_prod;

   assign mid_sum = {1'b0, rlo_ff} + {1'b0, rhi_ff};
   assign mid     = mid_sum[10:1];
   assign fb_sum  = {1'b0, flo_ff} + {1'b0, fhi_ff};
   assign fb      = fb_sum[11:1];
   assign pin     = quot[15:0];
   assign cur     = quot[31:0];

   // final scaling to 10 kHz units by reciprocal multiply
   assign fin_freq = found_ff ? b_freq_ff : NO_FREQ;
   assign dot_prod = fin_freq * DOT_RECIP;

   // operand selection for the shared divider
   always_comb begin
      case (cmd.div_sel)
         DIV_MID: begin
            div_num = NUM_W'(ref_clock_ff);
            div_den = DEN_W'(mid);
            div_top = TOP_PIN;
         end
         DIV_RD: begin
            div_num = NUM_W'(ref_clock_ff);
            div_den = DEN_W'(rd_ff[9:0]);
            div_top = TOP_PIN;
         end
         DIV_VCO: begin
            div_num = NUM_W'(ref_clock_ff * fb) + NUM_W'(rd_ff[9:1]);
            div_den = DEN_W'(rd_ff[9:0]);
            div_top = TOP_VCO;
         end
         DIV_CUR: begin
            div_num = NUM_W'(rc10k_ff * fb) + NUM_W'(rp_ff[16:1]);
            div_den = rp_ff;
            div_top = TOP_CUR;
         end
         default: begin
            div_num = '0;
            div_den = '1;
            div_top = TOP_PIN;
         end
      endcase
   end

   pds_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .top   (div_top),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   // candidate ranking
   always_comb begin
      err    = mag32(cur - target_ff[31:0]);
      vd     = mag32(vco_ff - pref_vco_ff);
      better = (pref_vco_ff == 32'd0) ? (err < b_err_ff) :
               ((err < (b_err_ff - ERR_WINDOW)) ||
                ((mag32(err - b_err_ff) < ERR_WINDOW) && (vd < b_vd_ff)));
      exact  = ({1'b0, cur} == target_ff);
      prefer = (flags_ff[FLG_LOW_REF]   && (rd_ff[9:0] < b_ref_ff)) ||
               (flags_ff[FLG_HIGH_REF]  && (rd_ff[9:0] > b_ref_ff)) ||
               (flags_ff[FLG_LOW_FB]    && (fb < b_fb_ff)) ||
               (flags_ff[FLG_HIGH_FB]   && (fb > b_fb_ff)) ||
               (flags_ff[FLG_LOW_POST]  && (post_ff[6:0] < b_post_ff)) ||
               (flags_ff[FLG_HIGH_POST] && (post_ff[6:0] > b_post_ff));
      take   = better || (exact && (!found_ff || prefer));
   end

   // derived products, held in registers ahead of the divider and the result
   always_ff @(posedge clock) begin
      rc10k_ff <= 30'(ref_clock_ff * FREQ_SCALE);
      rp_ff    <= 17'(rd_ff[9:0] * post_ff[6:0]);
      dot_ff   <= dot_prod[63:45];
   end

   // search loop registers
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load)
            found_ff <= 1'b0;
         else if (cmd.eval && take)
            found_ff <= 1'b1;
         if (cmd.rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         target_ff <= 33'(req_tdata[22:0] * KHZ_SCALE);
         flags_ff  <= req_tdata[31:23];
         rlo_ff    <= req_tdata[23 + FLG_FIXED_REF] ? fixed_ref_ff : REF_DIV_FLOOR;
         rhi_ff    <= req_tdata[23 + FLG_FIXED_REF] ? fixed_ref_ff : REF_DIV_CEIL;
         b_post_ff <= 7'd1;
         b_ref_ff  <= 10'd1;
         b_fb_ff   <= 11'd1;
         b_freq_ff <= NO_FREQ;
         b_err_ff  <= NO_FREQ;
         b_vd_ff   <= 32'd1;
      end
      if (cmd.rb_step) begin
         if (pin < pin_min_ff)
            rhi_ff <= mid;
         else
            rlo_ff <= mid;
      end
      if (cmd.post_init)
         post_ff <= POST_DIV_FIRST;
      else if (cmd.post_inc)
         post_ff <= post_ff + 8'd1;
      if (cmd.rd_init)
         rd_ff <= {1'b0, rlo_ff};
      else if (cmd.rd_inc)
         rd_ff <= rd_ff + 11'd1;
      if (cmd.vco_cap)
         vco_ff <= quot[31:0];
      if (cmd.fb_init) begin
         flo_ff <= MIN_FB_DIV;
         fhi_ff <= FB_DIV_LIMIT;
      end else if (cmd.vco_step) begin
         if (vco_ff < vco_min_ff)
            flo_ff <= {1'b0, fb} + 12'd1;
         else
            fhi_ff <= {1'b0, fb};
      end else if (cmd.eval) begin
         if ({1'b0, cur} < target_ff)
            flo_ff <= {1'b0, fb} + 12'd1;
         else
            fhi_ff <= {1'b0, fb};
      end
      if (cmd.eval && take) begin
         b_post_ff <= post_ff[6:0];
         b_ref_ff  <= rd_ff[9:0];
         b_fb_ff   <= fb;
         b_freq_ff <= cur;
         b_err_ff  <= err;
         b_vd_ff   <= vd;
      end
      if (cmd.rsp_load)
         rsp_data_ff <= {1'b0, b_post_ff, b_ref_ff, b_fb_ff, dot_ff};
   end

   // status back to the controller
   always_comb begin
      stat.div_done  = div_done;
      stat.rb_more   = !flags_ff[FLG_FIXED_REF] &&
                       (({1'b0, rlo_ff} + 11'd1) < {1'b0, rhi_ff});
      stat.pin_ok    = (pin >= pin_min_ff) && (pin <= pin_max_ff);
      stat.post_ok   = post_ff <= {1'b0, post_max_ff};
      stat.post_skip = (flags_ff[FLG_NO_ODD] && post_ff[0]) ||
                       (flags_ff[FLG_LEGACY] && legacy_skip(post_ff));
      stat.rd_ok     = rd_ff <= {1'b0, rhi_ff};
      stat.rd_zero   = rd_ff == 11'd0;
      stat.fb_more   = flo_ff < fhi_ff;
      stat.vco_ok    = (vco_ff >= vco_min_ff) && (vco_ff <= vco_max_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");
   a_found_sticks : assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && take) |=> found_ff) else $error("take did not mark found");
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy) else $error("division issued while busy");

endmodule

// ===== sv/pds_ctrl.sv =====
// search sequencer: walks the bisection and divider loops
module pds_ctrl
   import pds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  pds_stat_type stat,
   output pds_cmd_type  cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_RB_CHK   = 12'b0000_0000_0010,
      ST_RB_WAIT  = 12'b0000_0000_0100,
      ST_POST_CHK = 12'b0000_0000_1000,
      ST_RD_CHK   = 12'b0000_0001_0000,
      ST_PIN_WAIT = 12'b0000_0010_0000,
      ST_FB_CHK   = 12'b0000_0100_0000,
      ST_VCO_WAIT = 12'b0000_1000_0000,
      ST_VCO_CHK  = 12'b0001_0000_0000,
      ST_CUR_WAIT = 12'b0010_0000_0000,
      ST_FIN_WAIT = 12'b0100_0000_0000,
      ST_RSP_PUT  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_MID;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RB_CHK;
            end
         end
         ST_RB_CHK: begin
            if (stat.rb_more) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_MID;
               state_in      = ST_RB_WAIT;
            end else begin
               cmd.post_init = 1'b1;
               state_in      = ST_POST_CHK;
            end
         end
         ST_RB_WAIT: begin
            if (stat.div_done) begin
               if (stat.pin_ok) begin
                  cmd.post_init = 1'b1;
                  state_in      = ST_POST_CHK;
               end else begin
                  cmd.rb_step = 1'b1;
                  state_in    = ST_RB_CHK;
               end
            end
         end
         ST_POST_CHK: begin
            if (!stat.post_ok) begin
               state_in = ST_FIN_WAIT;
            end else if (stat.post_skip) begin
               cmd.post_inc = 1'b1;
            end else begin
               cmd.rd_init = 1'b1;
               state_in    = ST_RD_CHK;
            end
         end
         ST_RD_CHK: begin
            if (!stat.rd_ok) begin
               cmd.post_inc = 1'b1;
               state_in     = ST_POST_CHK;
            end else if (stat.rd_zero) begin
               cmd.rd_inc = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_RD;
               state_in      = ST_PIN_WAIT;
            end
         end
         ST_PIN_WAIT: begin
            if (stat.div_done) begin
               if (stat.pin_ok) begin
                  cmd.fb_init = 1'b1;
                  state_in    = ST_FB_CHK;
               end else begin
                  cmd.rd_inc = 1'b1;
                  state_in   = ST_RD_CHK;
               end
            end
         end
         ST_FB_CHK: begin
            if (stat.fb_more) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_VCO;
               state_in      = ST_VCO_WAIT;
            end else begin
               cmd.rd_inc = 1'b1;
               state_in   = ST_RD_CHK;
            end
         end
         ST_VCO_WAIT: begin
            if (stat.div_done) begin
               cmd.vco_cap = 1'b1;
               state_in    = ST_VCO_CHK;
            end
         end
         ST_VCO_CHK: begin
            if (stat.vco_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_CUR;
               state_in      = ST_CUR_WAIT;
            end else begin
               cmd.vco_step = 1'b1;
               state_in     = ST_FB_CHK;
            end
         end
         ST_CUR_WAIT: begin
            cmd.div_sel = DIV_CUR;
            if (stat.div_done) begin
               cmd.eval = 1'b1;
               state_in = ST_FB_CHK;
            end
         end
         // waits for the registered scaling of the best clock
         ST_FIN_WAIT: begin
            state_in = ST_RSP_PUT;
         end
         ST_RSP_PUT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_load_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_RB_CHK) else $error("load did not start search");
   a_rsp_from_put : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> state_ff == ST_IDLE) else $error("result load out of place");
   a_eval_after_cur : assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (state_ff == ST_CUR_WAIT && stat.div_done))
      else $error("evaluation without a finished clock division");

endmodule

// ===== sv/pll_divider_search.sv =====
// pll divider search top level: sequencer plus search datapath
//
// Usage: one request beat on req_ (target clock in kHz and option flags)
// starts a search for the post, reference and feedback dividers that come
// closest to the target. One result beat on rsp_ carries the achieved clock
// in 10 kHz units and the three dividers (1/1/1 and 429496 if none fits).
// Config registers are written on csr_ by the user only while no search
// is running; the block itself does not enforce this. Reference input,
// VCO and candidate clock divisions share one restoring divider at one
// quotient bit per cycle. A search bisects the reference range, then tries
// each reference divider in turn and bisects the feedback divider for it
// (up to 11 steps per post/reference pair; a step whose VCO is out of range
// skips the candidate clock division). The final scaling to 10 kHz units
// is a reciprocal multiply.
// One request is searched at a time; req_tready is high only when idle.
// The result sits in an output register, so a new request is taken while
// the last result waits; a stalled receiver holds the next result back.
// Reset loads the documented config defaults and empties the result slot.
module pll_divider_search
   import pds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: target_freq[22:0], option_flags[31:23]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // result: dot_clock[18:0], feedback_divider[29:19], reference_divider[39:30],
   // post_divider[46:40], zero fill[47]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   pds_cmd_type  cmd;
   pds_stat_type stat;

   pds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pds_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
